/* rtl/core/qrs_pkg.sv */
`timescale 1ns / 1ps

package qrs_pkg;

  localparam int COEF_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int ROOT_W     = 32;

  // Input and output beat layouts
  localparam int S_TDATA_W = ((3 * COEF_WIDTH + 7) / 8) * 8;
  localparam int M_TDATA_W = 4 * ROOT_W;
  localparam int M_TUSER_W = 3;

  // Discriminant: signed, and its magnitude
  localparam int DISC_W = 2 * COEF_WIDTH + 2;
  localparam int DMAG_W = 2 * COEF_WIDTH + 1;

  // Square root of |D| * 2^(2F), two radicand bits per cell
  localparam int RAD_RAW = DMAG_W + 2 * FRAC_BITS;
  localparam int RAD_W   = RAD_RAW + (RAD_RAW % 2);
  localparam int SQRT_W  = RAD_W / 2;
  localparam int SREM_W  = SQRT_W + 3;

  // -b scaled to the root's fraction
  localparam int NEGB_W = COEF_WIDTH + FRAC_BITS + 1;

  // Numerator magnitudes and their signed form
  localparam int NUM_W  = ((SQRT_W > COEF_WIDTH + FRAC_BITS) ? SQRT_W
                                                             : COEF_WIDTH + FRAC_BITS) + 1;
  localparam int NUMS_W = NUM_W + 1;

  // Divisor 2|a| and long-division remainder
  localparam int DIV_W  = COEF_WIDTH + 1;
  localparam int DREM_W = COEF_WIDTH + 2;

  localparam int SAT_W = (NUM_W > ROOT_W) ? NUM_W : ROOT_W + 1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_LEAD_ZERO = 2'd1,
    ST_SAT       = 2'd2
  } status_t;

  typedef struct packed {
    logic [NEGB_W-1:0]     negb;
    logic [COEF_WIDTH-1:0] ma;
    logic                  na;
    logic                  cplx;
    logic                  a_zero;
  } side_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [SREM_W-1:0] rem;
    logic [SQRT_W-1:0] root;
    side_t             side;
  } sqrt_bus_t;

  typedef struct packed {
    logic cplx;
    logic a_zero;
    logic neg1;
    logic neg2;
  } div_meta_t;

  typedef struct packed {
    logic [NUM_W-1:0]  num1;
    logic [NUM_W-1:0]  num2;
    logic [DREM_W-1:0] rem1;
    logic [DREM_W-1:0] rem2;
    logic [NUM_W-1:0]  quo1;
    logic [NUM_W-1:0]  quo2;
    logic [DIV_W-1:0]  dvs;
    div_meta_t         meta;
  } div_bus_t;

  typedef struct packed {
    logic [ROOT_W-1:0] value;
    logic              sat;
  } root_t;

  typedef struct packed {
    logic [M_TUSER_W-1:0] tuser;
    logic [M_TDATA_W-1:0] tdata;
  } result_t;

  // Apply sign to a quotient magnitude, clamping to the signed root range
  function automatic root_t sat_root(input logic [NUM_W-1:0] q, input logic neg);
    logic [SAT_W-1:0]  qe;
    logic [SAT_W-1:0]  lim;
    logic [ROOT_W-1:0] mag;
    root_t             r;
    qe    = SAT_W'(q);
    lim   = neg ? (SAT_W'(1) << (ROOT_W - 1))
                : ((SAT_W'(1) << (ROOT_W - 1)) - SAT_W'(1));
    r.sat = (qe > lim);
    mag   = r.sat ? lim[ROOT_W-1:0] : qe[ROOT_W-1:0];
    r.value = neg ? (~mag + ROOT_W'(1)) : mag;
    return r;
  endfunction

endpackage

/* rtl/core/qrs_sqrt_cell.sv */
`timescale 1ns / 1ps

// One restoring square-root digit: take two radicand bits, emit one root bit.
module qrs_sqrt_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  qrs_pkg::sqrt_bus_t in_bus,
  output logic               out_valid,
  output qrs_pkg::sqrt_bus_t out_bus
);

  logic [qrs_pkg::SREM_W-1:0] shifted;
  logic [qrs_pkg::SREM_W-1:0] trial;
  logic                       go;

  always_comb begin
    shifted = {in_bus.rem[qrs_pkg::SREM_W-3:0], in_bus.rad[qrs_pkg::RAD_W-1 -: 2]};
    trial   = (qrs_pkg::SREM_W'(in_bus.root) << 2) | qrs_pkg::SREM_W'(1);
    go      = (shifted >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_bus.rad  <= in_bus.rad << 2;
      out_bus.rem  <= go ? (shifted - trial) : shifted;
      out_bus.root <= {in_bus.root[qrs_pkg::SQRT_W-2:0], go};
      out_bus.side <= in_bus.side;
    end
  end

endmodule

/* rtl/core/qrs_div_cell.sv */
`timescale 1ns / 1ps

// One long-division step for both numerator lanes against a shared divisor.
module qrs_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  qrs_pkg::div_bus_t in_bus,
  output logic              out_valid,
  output qrs_pkg::div_bus_t out_bus
);

  logic [qrs_pkg::DREM_W-1:0] s1;
  logic [qrs_pkg::DREM_W-1:0] s2;
  logic [qrs_pkg::DREM_W-1:0] d;
  logic                       go1;
  logic                       go2;

  always_comb begin
    d   = qrs_pkg::DREM_W'(in_bus.dvs);
    s1  = {in_bus.rem1[qrs_pkg::DREM_W-2:0], in_bus.num1[qrs_pkg::NUM_W-1]};
    s2  = {in_bus.rem2[qrs_pkg::DREM_W-2:0], in_bus.num2[qrs_pkg::NUM_W-1]};
    go1 = (s1 >= d);
    go2 = (s2 >= d);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_bus.num1 <= in_bus.num1 << 1;
      out_bus.num2 <= in_bus.num2 << 1;
      out_bus.rem1 <= go1 ? (s1 - d) : s1;
      out_bus.rem2 <= go2 ? (s2 - d) : s2;
      out_bus.quo1 <= {in_bus.quo1[qrs_pkg::NUM_W-2:0], go1};
      out_bus.quo2 <= {in_bus.quo2[qrs_pkg::NUM_W-2:0], go2};
      out_bus.dvs  <= in_bus.dvs;
      out_bus.meta <= in_bus.meta;
    end
  end

endmodule

/* rtl/core/qrs_out_stage.sv */
`timescale 1ns / 1ps

// Sign, clamp and pack the roots; output register plus skid register.
module qrs_out_stage (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  qrs_pkg::div_bus_t               in_bus,
  output logic                            in_ready,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [qrs_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic [qrs_pkg::M_TUSER_W-1:0]   m_tuser
);

  qrs_pkg::root_t   r1;
  qrs_pkg::root_t   r2;
  qrs_pkg::root_t   r3;
  qrs_pkg::result_t res;
  qrs_pkg::result_t out_data;
  qrs_pkg::result_t skid_data;
  qrs_pkg::status_t st;
  logic             skid_valid;
  logic             push;
  logic             sat;

  always_comb begin
    r1 = qrs_pkg::sat_root(in_bus.quo1, in_bus.meta.neg1);
    r2 = qrs_pkg::sat_root(in_bus.quo2, in_bus.meta.neg2);
    r3 = qrs_pkg::sat_root(in_bus.quo2, ~in_bus.meta.neg2);
    if (in_bus.meta.a_zero) begin
      sat       = 1'b0;
      st        = qrs_pkg::ST_LEAD_ZERO;
      res.tdata = '0;
      res.tuser = {st, 1'b0};
    end else if (in_bus.meta.cplx) begin
      sat       = r1.sat | r2.sat | r3.sat;
      st        = sat ? qrs_pkg::ST_SAT : qrs_pkg::ST_OK;
      res.tdata = {r3.value, r1.value, r2.value, r1.value};
      res.tuser = {st, 1'b1};
    end else begin
      sat       = r1.sat | r2.sat;
      st        = sat ? qrs_pkg::ST_SAT : qrs_pkg::ST_OK;
      res.tdata = {qrs_pkg::ROOT_W'(0), r2.value, qrs_pkg::ROOT_W'(0), r1.value};
      res.tuser = {st, 1'b0};
    end
  end

  assign in_ready = ~skid_valid;
  assign push     = in_valid & ~skid_valid;
  assign m_tdata  = out_data.tdata;
  assign m_tuser  = out_data.tuser;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      out_data <= skid_valid ? skid_data : res;
    end else if (push) begin
      skid_data <= res;
    end
  end

endmodule

/* rtl/core/quadratic_root_solver.sv */
`timescale 1ns / 1ps

// Quadratic root solver: each input beat carries a, b, c of a*x^2 + b*x + c as signed
// Q16.16 and yields one output beat with both roots as complex pairs in Q16.16,
// truncated toward zero and clamped to the 32-bit range. The discriminant
// b*b - 4ac is formed exactly; its square root comes from a row of 49 digit cells
// (two radicand bits, one root bit each), and the division by 2a from a row of 50
// long-division cells that serve both roots at once. One beat enters per clock
// cycle while the pipeline is not held; the pipeline has 4 front stages, 49 root
// cells, 2 numerator stages, 50 division cells and 1 output register. A skid
// register at the output keeps s_tready high for one more beat while a result
// waits on m_tready; after that the whole pipeline holds. tuser carries
// roots_complex (1 for a conjugate pair) and status: 0 ok, 1 leading coefficient
// zero (all roots read 0), 2 some root part clamped.
module quadratic_root_solver (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // coef_a [31:0], coef_b [63:32], coef_c [95:64]
  input  logic [qrs_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // first_root_real [31:0], first_root_imag [63:32],
  // second_root_real [95:64], second_root_imag [127:96]
  output logic [qrs_pkg::M_TDATA_W-1:0] m_tdata,
  // roots_complex [0], status [2:1]
  output logic [qrs_pkg::M_TUSER_W-1:0] m_tuser
);

  localparam int CW = qrs_pkg::COEF_WIDTH;

  logic en;

  // Input magnitudes and signs
  logic [CW-1:0] a_in;
  logic [CW-1:0] b_in;
  logic [CW-1:0] c_in;

  logic          v1;
  logic [CW-1:0] ma1;
  logic [CW-1:0] mb1;
  logic [CW-1:0] mc1;
  logic          na1;
  logic          nb1;
  logic          nc1;

  // Products
  logic              v2;
  logic [2*CW-1:0]   pbb2;
  logic [2*CW-1:0]   pac2;
  logic              nac2;
  logic [CW-1:0]     ma2;
  logic [CW-1:0]     mb2;
  logic              na2;
  logic              nb2;

  // Discriminant
  logic                       v3;
  logic [qrs_pkg::DISC_W-1:0] disc3;
  logic [CW-1:0]              ma3;
  logic [CW-1:0]              mb3;
  logic                       na3;
  logic                       nb3;

  logic [qrs_pkg::DMAG_W-1:0] dmag;
  logic [qrs_pkg::NEGB_W-1:0] bsh;

  // Root cell chain
  logic                     sqrt_v0;
  qrs_pkg::sqrt_bus_t       sqrt_b0;
  logic [qrs_pkg::SQRT_W:0] sqrt_v;
  qrs_pkg::sqrt_bus_t       sqrt_b [qrs_pkg::SQRT_W+1];

  // Numerator stages
  qrs_pkg::sqrt_bus_t         sq_last;
  logic [qrs_pkg::NUMS_W-1:0] negb_x;
  logic [qrs_pkg::NUMS_W-1:0] root_x;
  logic                       va;
  logic [qrs_pkg::NUMS_W-1:0] lane1;
  logic [qrs_pkg::NUMS_W-1:0] lane2;
  logic [CW-1:0]              maa;
  logic                       naa;
  logic                       cplxa;
  logic                       aza;

  // Division cell chain
  logic                    div_v0;
  qrs_pkg::div_bus_t       div_b0;
  logic [qrs_pkg::NUM_W:0] div_v;
  qrs_pkg::div_bus_t       div_b [qrs_pkg::NUM_W+1];
  logic [qrs_pkg::NUMS_W-1:0] mag1;
  logic [qrs_pkg::NUMS_W-1:0] mag2;

  // Advance everything unless the skid register is occupied
  assign s_tready = en;

  assign a_in = s_tdata[CW-1:0];
  assign b_in = s_tdata[2*CW-1:CW];
  assign c_in = s_tdata[3*CW-1:2*CW];

  assign sqrt_v[0] = sqrt_v0;
  assign sqrt_b[0] = sqrt_b0;
  assign div_v[0]  = div_v0;
  assign div_b[0]  = div_b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      sqrt_v0 <= 1'b0;
      va <= 1'b0;
      div_v0 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      sqrt_v0 <= v3;
      va <= sqrt_v[qrs_pkg::SQRT_W];
      div_v0 <= va;
    end
  end

  // Stage 1: take magnitudes of the coefficients
  always_ff @(posedge clk) begin
    if (en) begin
      na1 <= a_in[CW-1];
      nb1 <= b_in[CW-1];
      nc1 <= c_in[CW-1];
      ma1 <= a_in[CW-1] ? (~a_in + CW'(1)) : a_in;
      mb1 <= b_in[CW-1] ? (~b_in + CW'(1)) : b_in;
      mc1 <= c_in[CW-1] ? (~c_in + CW'(1)) : c_in;
    end
  end

  // Stage 2: b*b and a*c on magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      pbb2 <= (2*CW)'(mb1) * (2*CW)'(mb1);
      pac2 <= (2*CW)'(ma1) * (2*CW)'(mc1);
      nac2 <= na1 ^ nc1;
      ma2  <= ma1;
      mb2  <= mb1;
      na2  <= na1;
      nb2  <= nb1;
    end
  end

  // Stage 3: discriminant; 4ac adds when a and c differ in sign
  always_ff @(posedge clk) begin
    if (en) begin
      disc3 <= nac2 ? (qrs_pkg::DISC_W'(pbb2) + (qrs_pkg::DISC_W'(pac2) << 2))
                    : (qrs_pkg::DISC_W'(pbb2) - (qrs_pkg::DISC_W'(pac2) << 2));
      ma3 <= ma2;
      mb3 <= mb2;
      na3 <= na2;
      nb3 <= nb2;
    end
  end

  // Stage 4: |D| as radicand and -b scaled, feeding the first root cell
  always_comb begin
    dmag = disc3[qrs_pkg::DISC_W-1] ? qrs_pkg::DMAG_W'(~disc3 + qrs_pkg::DISC_W'(1))
                                    : disc3[qrs_pkg::DMAG_W-1:0];
    bsh  = qrs_pkg::NEGB_W'(mb3) << qrs_pkg::FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqrt_b0.rad         <= qrs_pkg::RAD_W'(dmag) << (2 * qrs_pkg::FRAC_BITS);
      sqrt_b0.rem         <= '0;
      sqrt_b0.root        <= '0;
      sqrt_b0.side.negb   <= nb3 ? bsh : (~bsh + qrs_pkg::NEGB_W'(1));
      sqrt_b0.side.ma     <= ma3;
      sqrt_b0.side.na     <= na3;
      sqrt_b0.side.cplx   <= disc3[qrs_pkg::DISC_W-1];
      sqrt_b0.side.a_zero <= (ma3 == '0);
    end
  end

  for (genvar i = 0; i < qrs_pkg::SQRT_W; i++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (sqrt_v[i]),
      .in_bus    (sqrt_b[i]),
      .out_valid (sqrt_v[i+1]),
      .out_bus   (sqrt_b[i+1])
    );
  end

  // Numerators: real roots take -b +/- S, a conjugate pair takes -b and S
  always_comb begin
    sq_last = sqrt_b[qrs_pkg::SQRT_W];
    negb_x  = {{(qrs_pkg::NUMS_W - qrs_pkg::NEGB_W){sq_last.side.negb[qrs_pkg::NEGB_W-1]}},
               sq_last.side.negb};
    root_x  = qrs_pkg::NUMS_W'(sq_last.root);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane1 <= sq_last.side.cplx ? negb_x : (negb_x + root_x);
      lane2 <= sq_last.side.cplx ? root_x : (negb_x - root_x);
      maa   <= sq_last.side.ma;
      naa   <= sq_last.side.na;
      cplxa <= sq_last.side.cplx;
      aza   <= sq_last.side.a_zero;
    end
  end

  // Split numerators into magnitude and result sign, feeding the first divider cell
  always_comb begin
    mag1 = lane1[qrs_pkg::NUMS_W-1] ? (~lane1 + qrs_pkg::NUMS_W'(1)) : lane1;
    mag2 = lane2[qrs_pkg::NUMS_W-1] ? (~lane2 + qrs_pkg::NUMS_W'(1)) : lane2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_b0.num1        <= mag1[qrs_pkg::NUM_W-1:0];
      div_b0.num2        <= mag2[qrs_pkg::NUM_W-1:0];
      div_b0.rem1        <= '0;
      div_b0.rem2        <= '0;
      div_b0.quo1        <= '0;
      div_b0.quo2        <= '0;
      div_b0.dvs         <= {maa, 1'b0};
      div_b0.meta.cplx   <= cplxa;
      div_b0.meta.a_zero <= aza;
      div_b0.meta.neg1   <= lane1[qrs_pkg::NUMS_W-1] ^ naa;
      div_b0.meta.neg2   <= cplxa ? naa : (lane2[qrs_pkg::NUMS_W-1] ^ naa);
    end
  end

  for (genvar j = 0; j < qrs_pkg::NUM_W; j++) begin : g_div
    qrs_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (div_v[j]),
      .in_bus    (div_b[j]),
      .out_valid (div_v[j+1]),
      .out_bus   (div_b[j+1])
    );
  end

  qrs_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (div_v[qrs_pkg::NUM_W]),
    .in_bus   (div_b[qrs_pkg::NUM_W]),
    .in_ready (en),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

/* rtl/core/qrs_checker.sv */
`timescale 1ns / 1ps

module qrs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [qrs_pkg::S_TDATA_W-1:0] s_tdata,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [qrs_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [qrs_pkg::M_TUSER_W-1:0] m_tuser
);

  localparam int RW = qrs_pkg::ROOT_W;

  // Hold a stalled output beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

  // Zero leading coefficient gives zero roots and no conjugate pair
  a_lead_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2:1] == qrs_pkg::ST_LEAD_ZERO) |-> (m_tdata == '0) && !m_tuser[0])
    else $error("nonzero roots with zero leading coefficient");

  // Real roots carry no imaginary parts
  a_real_imag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tdata[2*RW-1:RW] == '0) && (m_tdata[4*RW-1:3*RW] == '0))
    else $error("real roots with imaginary part");

  // A conjugate pair shares its real part
  a_conj_real: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata[RW-1:0] == m_tdata[3*RW-1:2*RW]))
    else $error("conjugate pair with differing real parts");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[2:1] != 2'd3))
    else $error("undefined status code");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (.*);
